// File: rtl/vdn_pkg.sv
`default_nettype none
package vdn_pkg;
	// component width of one point coordinate
	localparam int COMPONENT_BITS = 16;
	// fraction bits of the unit vector
	localparam int UNIT_FRACTION_BITS = 14;
endpackage
`default_nettype wire

// File: rtl/vdn_pt_if.sv
`default_nettype none
interface vdn_pt_if #(
	parameter int CB = vdn_pkg::COMPONENT_BITS
);
	logic valid;
	logic ready;
	logic signed [CB-1:0] start_x;
	logic signed [CB-1:0] start_y;
	logic signed [CB-1:0] start_z;
	logic signed [CB-1:0] finish_x;
	logic signed [CB-1:0] finish_y;
	logic signed [CB-1:0] finish_z;
	modport source(output valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
		input ready);
	modport sink(input valid, start_x, start_y, start_z, finish_x, finish_y, finish_z,
		output ready);
endinterface
`default_nettype wire

// File: rtl/vdn_res_if.sv
`default_nettype none
interface vdn_res_if #(
	parameter int CB = vdn_pkg::COMPONENT_BITS,
	parameter int UF = vdn_pkg::UNIT_FRACTION_BITS
);
	localparam int SQB = 2 * CB + 2;
	localparam int LB = CB + 1;
	localparam int UB = UF + 2;
	logic valid;
	logic ready;
	logic [SQB-1:0] dist_squared;
	logic [LB-1:0] dist_res;
	logic signed [UB-1:0] unit_x;
	logic signed [UB-1:0] unit_y;
	logic signed [UB-1:0] unit_z;
	logic zero_length;
	modport source(output valid, dist_squared, dist_res, unit_x, unit_y, unit_z, zero_length,
		input ready);
	modport sink(input valid, dist_squared, dist_res, unit_x, unit_y, unit_z, zero_length,
		output ready);
endinterface
`default_nettype wire

// File: rtl/vdn_lane.sv
`default_nettype none
module vdn_lane #(
	parameter int CB = vdn_pkg::COMPONENT_BITS,
	parameter int UF = vdn_pkg::UNIT_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic adv,
	input wire logic signed [CB-1:0] a_start,
	input wire logic signed [CB-1:0] a_finish,
	input wire logic [2*CB+1:0] sq_pipe [(((CB+1) > (UF+1)) ? (CB+1) : (UF+1)) + 1],
	output logic [2*CB+1:0] mag2_s2,
	output logic signed [UF+1:0] unit
);
	localparam int SQB = 2 * CB + 2;
	localparam int LB = CB + 1;
	localparam int UB = UF + 2;
	localparam int NS = (LB > UF + 1) ? LB : UF + 1;
	localparam int W = SQB + 2 * UF + 3;
	localparam int SW = SQB + UF + 1;

	logic signed [LB-1:0] d_s1;
	logic neg_s2;
	logic [W-1:0] r_p [NS+1];
	logic [SW-1:0] s_p [NS+1];
	logic [UF:0] q_p [NS+1];
	logic neg_p [NS+1];
	logic [LB-1:0] mag;

	// difference and its square
	assign mag = d_s1[LB-1] ? (LB'(0) - LB'(d_s1)) : LB'(d_s1);
	always_ff @(posedge clk) begin
		if (adv) begin
			d_s1 <= LB'({a_finish[CB-1], a_finish}) - LB'({a_start[CB-1], a_start});
			neg_s2 <= d_s1[LB-1];
			mag2_s2 <= mag * mag;
			r_p[0] <= W'(mag2_s2) << (2 * UF);
			s_p[0] <= '0;
			q_p[0] <= '0;
			neg_p[0] <= neg_s2;
		end
	end

	// one quotient bit per stage, then pass-through stages: keep r = mag^2*2^2uf - q^2*sq and s = q*sq
	for (genvar k = 0; k < NS; k++) begin : g_stage
		if (k <= UF) begin : g_bit
			localparam int B = UF - k;
			logic [W-1:0] t;
			logic ge;
			assign t = (W'(s_p[k]) << (B + 1)) + (W'(sq_pipe[k]) << (2 * B));
			assign ge = r_p[k] >= t;
			always_ff @(posedge clk) begin
				if (adv) begin
					r_p[k+1] <= ge ? r_p[k] - t : r_p[k];
					s_p[k+1] <= ge ? s_p[k] + (SW'(sq_pipe[k]) << B) : s_p[k];
					q_p[k+1] <= ge ? (q_p[k] | ((UF+1)'(1) << B)) : q_p[k];
					neg_p[k+1] <= neg_p[k];
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					r_p[k+1] <= r_p[k];
					s_p[k+1] <= s_p[k];
					q_p[k+1] <= q_p[k];
					neg_p[k+1] <= neg_p[k];
				end
			end
		end
	end

	// sign and zero-length override
	always_comb begin
		if (sq_pipe[NS] == '0) begin
			unit = '0;
		end else if (neg_p[NS]) begin
			unit = UB'(0) - UB'(q_p[NS]);
		end else begin
			unit = UB'(q_p[NS]);
		end
	end
endmodule
`default_nettype wire

// File: rtl/vdn_sqrt.sv
`default_nettype none
module vdn_sqrt #(
	parameter int CB = vdn_pkg::COMPONENT_BITS,
	parameter int UF = vdn_pkg::UNIT_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic adv,
	input wire logic [2*CB+1:0] sq_pipe [(((CB+1) > (UF+1)) ? (CB+1) : (UF+1)) + 1],
	output logic [CB:0] root
);
	localparam int SQB = 2 * CB + 2;
	localparam int LB = CB + 1;
	localparam int NS = (LB > UF + 1) ? LB : UF + 1;

	logic [LB+1:0] rem_p [NS+1];
	logic [LB-1:0] root_p [NS+1];

	// restoring square root, two radicand bits per stage
	for (genvar k = 0; k < NS; k++) begin : g_stage
		if (k < LB) begin : g_step
			logic [LB+1:0] rm;
			logic [LB+1:0] t;
			logic ge;
			if (k == 0) begin : g_first
				assign rm = (LB+2)'(sq_pipe[k][SQB-1 -: 2]);
				assign t = (LB+2)'(1);
			end else begin : g_next
				assign rm = {rem_p[k][LB-1:0], sq_pipe[k][SQB-1-2*k -: 2]};
				assign t = {root_p[k], 2'b01};
			end
			assign ge = rm >= t;
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_p[k+1] <= ge ? rm - t : rm;
					if (k == 0) begin
						root_p[k+1] <= LB'(ge);
					end else begin
						root_p[k+1] <= {root_p[k][LB-2:0], ge};
					end
				end
			end
		end else begin : g_pass
			always_ff @(posedge clk) begin
				if (adv) begin
					rem_p[k+1] <= rem_p[k];
					root_p[k+1] <= root_p[k];
				end
			end
		end
	end

	assign root = root_p[NS];
endmodule
`default_nettype wire

// File: rtl/vector3_distance_normalize_core.sv
`default_nettype none
// stages in order: difference, square, merge, then the root and quotient stages
// throughput: one beat per cycle while the output is not stalled; the square root and
// the three unit lanes each retire one bit per pipeline stage, so depth follows the wider of root and quotient
// the whole pipeline stalls while a result waits at the output
// reset: arst_n clears the stage valid bits only; no other state
module vector3_distance_normalize_core #(
	parameter int CB = vdn_pkg::COMPONENT_BITS,
	parameter int UF = vdn_pkg::UNIT_FRACTION_BITS
) (
	input wire logic clk,
	input wire logic arst_n,
	vdn_pt_if.sink pt,
	vdn_res_if.source res
);
	localparam int SQB = 2 * CB + 2;
	localparam int LB = CB + 1;
	localparam int NS = (LB > UF + 1) ? LB : UF + 1;

	logic adv;
	logic vld_s1, vld_s2;
	logic vld_p [NS+1];
	logic [SQB-1:0] sq_p [NS+1];
	logic [SQB-1:0] m2x, m2y, m2z;

	assign adv = !vld_p[NS] || res.ready;
	assign pt.ready = adv;

	// lane per component
	vdn_lane #(.CB(CB), .UF(UF)) u_lane_x (
		.clk(clk), .adv(adv), .a_start(pt.start_x), .a_finish(pt.finish_x),
		.sq_pipe(sq_p), .mag2_s2(m2x), .unit(res.unit_x)
	);
	vdn_lane #(.CB(CB), .UF(UF)) u_lane_y (
		.clk(clk), .adv(adv), .a_start(pt.start_y), .a_finish(pt.finish_y),
		.sq_pipe(sq_p), .mag2_s2(m2y), .unit(res.unit_y)
	);
	vdn_lane #(.CB(CB), .UF(UF)) u_lane_z (
		.clk(clk), .adv(adv), .a_start(pt.start_z), .a_finish(pt.finish_z),
		.sq_pipe(sq_p), .mag2_s2(m2z), .unit(res.unit_z)
	);

	vdn_sqrt #(.CB(CB), .UF(UF)) u_sqrt (
		.clk(clk), .adv(adv), .sq_pipe(sq_p), .root(res.dist_res)
	);

	// merge: squared length and its delay line
	always_ff @(posedge clk) begin
		if (adv) begin
			sq_p[0] <= m2x + m2y + m2z;
		end
	end
	for (genvar k = 0; k < NS; k++) begin : g_sq
		always_ff @(posedge clk) begin
			if (adv) begin
				sq_p[k+1] <= sq_p[k];
			end
		end
	end

	// stage valid bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_p[0] <= 1'b0;
		end else if (adv) begin
			vld_s1 <= pt.valid;
			vld_s2 <= vld_s1;
			vld_p[0] <= vld_s2;
		end
	end
	for (genvar k = 0; k < NS; k++) begin : g_vld
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_p[k+1] <= 1'b0;
			end else if (adv) begin
				vld_p[k+1] <= vld_p[k];
			end
		end
	end

	assign res.valid = vld_p[NS];
	assign res.dist_squared = sq_p[NS];
	assign res.zero_length = (sq_p[NS] == '0);

	// checks
	a_zero_units: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && res.zero_length |-> res.unit_x == '0 && res.unit_y == '0
		&& res.unit_z == '0)
		else $error("unit vector not zero at zero length");
	a_root_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid && !res.zero_length |-> res.dist_res != '0)
		else $error("zero root for nonzero length");
	a_root_floor: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (2*SQB)'(res.dist_res) * (2*SQB)'(res.dist_res)
		<= (2*SQB)'(res.dist_squared))
		else $error("root exceeds floor square root");
endmodule
`default_nettype wire
